### rtl/lrt_pkg.sv
// Package for the LRU residency tracker: field widths, result codes,
// controller states and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package lrt_pkg;

    // Default number of resident slots.
    localparam int LRT_ENTRIES = 16;

    localparam int LRT_KEY_W     = 64;
    localparam int LRT_CAP_W     = 5;
    localparam int LRT_IN_DATA_W = 136;  // key_hi, key_lo, open_ok, zero fill
    localparam int LRT_OUT_DATA_W = 136; // out_key_hi, out_key_lo, status, zero fill

    typedef enum logic [1:0] {
        KIND_EVICT   = 2'd0,
        KIND_ACCESS  = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_OPENED = 2'd1,
        ST_FAILED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_PRE_EVICT,
        S_INSERT,
        S_TRIM,
        S_REL_EVICT,
        S_FINAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;       // capture the incoming word
        logic    lookup;      // register the associative match
        logic    touch;       // move the hit entry to most recent
        logic    insert;      // write the key into a free slot as most recent
        logic    evict;       // drop the least recent entry and report it
        logic    emit_final;  // load the closing word of the request
        t_kind   kind;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic hit;
        logic open_ok;
        logic count_zero;
        logic full;
        logic over_cap;
        logic out_free;
    } t_sts;

endpackage

### rtl/lru_residency_tracker_core.sv
// Top level of the LRU residency tracker: joins the controller and datapath.
// A hit or failed open passes lookup, decide and final before its word is registered.
// One request at a time: a new word is taken only in the idle state, reached once the
// closing word is loaded; each eviction word and each sink stall holds up the request.
// Reset: synchronous active low; empties the tracker and sets capacity to one.
`timescale 1ns / 1ps

module lru_residency_tracker_core #(
    parameter int ENTRIES = lrt_pkg::LRT_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request words.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: key_hi[63:0], key_lo[127:64], open_ok[128], zero fill.
    input  logic [lrt_pkg::LRT_IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type (0 access a key, 1 release all).
    input  logic                               s_axis_tuser,
    // Result words.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: out_key_hi[63:0], out_key_lo[127:64], status[129:128],
    // zero fill.
    output logic [lrt_pkg::LRT_OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: kind (0 eviction, 1 access done, 2 release done).
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    // Capacity register write.
    input  logic                               i_cfg_wr_en,
    input  logic [lrt_pkg::LRT_CAP_W-1:0]      i_cfg_wr_data
);
    import lrt_pkg::*;

    // Commands flow one way and status the other; the datapath owns all state
    // except the request sequencing, which lives in the controller.
    t_cmd w_cmd;
    t_sts w_sts;

    lrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the output word register, so the next request can be
    // taken while the last word of the previous one still waits on the sink.
    lrt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_user    (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule

### rtl/lrt_datapath.sv
// Datapath of the LRU residency tracker: key store, recency ranks, capacity
// register and output word register. Depends on lrt_pkg.
`timescale 1ns / 1ps

module lrt_datapath #(
    parameter int ENTRIES = lrt_pkg::LRT_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lrt_pkg::LRT_IN_DATA_W-1:0] i_in_data,
    input  logic                              i_in_user,
    input  logic                              i_cfg_wr_en,
    input  logic [lrt_pkg::LRT_CAP_W-1:0]     i_cfg_wr_data,
    input  lrt_pkg::t_cmd                     i_cmd,
    output lrt_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lrt_pkg::LRT_OUT_DATA_W-1:0] o_out_data,
    output logic [1:0]                        o_out_user,
    output logic                              o_out_last
);
    import lrt_pkg::*;

    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > LRT_CAP_W) ? CW : LRT_CAP_W;

    logic [LRT_KEY_W-1:0] r_req_key_hi, r_req_key_lo;
    logic                 r_req_type, r_open_ok;
    logic [LRT_CAP_W-1:0] r_capacity;

    logic [LRT_KEY_W-1:0] r_key_hi_mem [ENTRIES];
    logic [LRT_KEY_W-1:0] r_key_lo_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;
    logic [RW-1:0]        r_rank [ENTRIES];
    logic [CW-1:0]        r_count;
    logic [ENTRIES-1:0]   r_hit_vec;
    logic                 r_hit;

    logic                 r_out_valid;
    logic [LRT_KEY_W-1:0] r_out_key_hi, r_out_key_lo;
    t_status              r_out_status;
    t_kind                r_out_kind;
    logic                 r_out_last;

    logic [ENTRIES-1:0]   w_match_vec, w_free_vec, w_victim_vec;
    logic [LRT_KEY_W-1:0] w_victim_hi, w_victim_lo;
    logic [RW-1:0]        w_hit_rank, w_oldest_rank;
    logic [CW-1:0]        w_count_m1;
    logic [CMPW-1:0]      w_cap, w_eff_cap;
    logic                 w_found, w_out_free;

    assign w_count_m1    = r_count - 1'b1;
    assign w_oldest_rank = w_count_m1[RW-1:0];

    always_comb begin
        w_found     = 1'b0;
        w_hit_rank  = '0;
        w_victim_hi = '0;
        w_victim_lo = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match_vec[i] = r_valid[i] && (r_key_hi_mem[i] == r_req_key_hi)
                             && (r_key_lo_mem[i] == r_req_key_lo);
            // Ranks of valid entries are always 0..count-1, so the oldest is unique.
            w_victim_vec[i] = r_valid[i] && (r_rank[i] == w_oldest_rank);
            w_free_vec[i]   = !r_valid[i] && !w_found;
            if (!r_valid[i]) begin
                w_found = 1'b1;
            end
            if (r_hit_vec[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
            if (w_victim_vec[i]) begin
                w_victim_hi = w_victim_hi | r_key_hi_mem[i];
                w_victim_lo = w_victim_lo | r_key_lo_mem[i];
            end
        end
    end

    // A written zero acts as one; anything above the slot count saturates.
    always_comb begin
        w_cap = CMPW'(r_capacity);
        if (r_capacity == '0) begin
            w_cap = CMPW'(1);
        end
        w_eff_cap = (w_cap > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : w_cap;
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.is_release = r_req_type;
        o_sts.hit        = r_hit;
        o_sts.open_ok    = r_open_ok;
        o_sts.count_zero = (r_count == '0);
        o_sts.full       = (r_count == CW'(ENTRIES));
        o_sts.over_cap   = (CMPW'(r_count) > w_eff_cap);
        o_sts.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LRT_CAP_W'(1);
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req_type   <= i_in_user;
            r_req_key_hi <= i_in_data[LRT_KEY_W-1:0];
            r_req_key_lo <= i_in_data[2*LRT_KEY_W-1:LRT_KEY_W];
            r_open_ok    <= i_in_data[2*LRT_KEY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_vec <= '0;
            r_hit     <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_hit_vec <= w_match_vec;
            r_hit     <= |w_match_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.insert && w_free_vec[i]) begin
                r_key_hi_mem[i] <= r_req_key_hi;
                r_key_lo_mem[i] <= r_req_key_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_cmd.touch) begin
                    if (r_hit_vec[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end else if (i_cmd.insert) begin
                    if (w_free_vec[i]) begin
                        r_rank[i]  <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end else if (i_cmd.evict && w_victim_vec[i]) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.evict) begin
                r_count <= w_count_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.evict || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.evict) begin
            r_out_kind   <= KIND_EVICT;
            r_out_key_hi <= w_victim_hi;
            r_out_key_lo <= w_victim_lo;
            r_out_status <= ST_HIT;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_kind   <= i_cmd.kind;
            r_out_key_hi <= (i_cmd.kind == KIND_RELEASE) ? '0 : r_req_key_hi;
            r_out_key_lo <= (i_cmd.kind == KIND_RELEASE) ? '0 : r_req_key_lo;
            r_out_status <= i_cmd.status;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{(LRT_OUT_DATA_W - 2*LRT_KEY_W - 2){1'b0}}, r_out_status,
                          r_out_key_lo, r_out_key_hi};

endmodule

### rtl/lrt_ctrl.sv
// Controller state machine of the LRU residency tracker; sequences lookup,
// touch, insertion, evictions and the closing word. Depends on lrt_pkg.
`timescale 1ns / 1ps

module lrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lrt_pkg::t_sts i_sts,
    output lrt_pkg::t_cmd o_cmd
);
    import lrt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.kind   = KIND_ACCESS;
        o_cmd.status = ST_HIT;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.is_release) begin
                    n_state = S_REL_EVICT;
                end else if (i_sts.hit) begin
                    o_cmd.touch = 1'b1;
                    n_state     = S_FINAL;
                end else if (!i_sts.open_ok) begin
                    n_state = S_FINAL;
                end else if (i_sts.full) begin
                    n_state = S_PRE_EVICT;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_PRE_EVICT: begin
                if (i_sts.out_free) begin
                    o_cmd.evict = 1'b1;
                    n_state     = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_TRIM;
            end
            S_TRIM: begin
                if (!i_sts.over_cap) begin
                    n_state = S_FINAL;
                end else if (i_sts.out_free) begin
                    o_cmd.evict = 1'b1;
                end
            end
            S_REL_EVICT: begin
                if (i_sts.count_zero) begin
                    n_state = S_FINAL;
                end else if (i_sts.out_free) begin
                    o_cmd.evict = 1'b1;
                end
            end
            S_FINAL: begin
                if (i_sts.is_release) begin
                    o_cmd.kind = KIND_RELEASE;
                end else if (i_sts.hit) begin
                    o_cmd.status = ST_HIT;
                end else if (!i_sts.open_ok) begin
                    o_cmd.status = ST_FAILED;
                end else begin
                    o_cmd.status = ST_OPENED;
                end
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/lrt_checker.sv
// Port-level checks for the LRU residency tracker, bound to the top level.
// Depends on lrt_pkg.
`timescale 1ns / 1ps

module lrt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lrt_pkg::LRT_OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                         m_axis_tuser,
    input logic                               m_axis_tlast
);
    import lrt_pkg::*;

    // One request at a time: after a word is taken the input closes.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_EVICT)) |-> !m_axis_tlast)
        else $error("eviction word marked last");

    a_release_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_RELEASE))
            |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("release word not last or carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind lru_residency_tracker_core lrt_checker u_lrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### sim/tb_lru_residency_tracker_core.sv
// Testbench for lru_residency_tracker_core: drives request words and capacity writes,
// predicts every result word with its own LRU tracker and checks them in order.
// Depends on lrt_pkg and the RTL top level only.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the tracker state and the queue of
// result words still due from the block.
class lru_scoreboard;
    typedef struct packed {
        lrt_pkg::t_kind   kind;
        logic [63:0]      key_hi;
        logic [63:0]      key_lo;
        lrt_pkg::t_status status;
        logic             last;
    } t_word;

    logic [63:0] slot_hi [16];
    logic [63:0] slot_lo [16];
    bit          slot_used [16];
    int          slot_age [16];
    int          used_count;
    int          cap_reg;
    t_word       due_words [$];
    int          mismatches;

    function new();
        for (int i = 0; i < 16; i++) begin
            slot_used[i] = 0;
            slot_age[i] = 0;
        end
        used_count = 0;
        cap_reg = 1;
        mismatches = 0;
    endfunction

    function void set_capacity(int value);
        cap_reg = value;
    endfunction

    function void push_word(lrt_pkg::t_kind k, logic [63:0] h, logic [63:0] l,
                            lrt_pkg::t_status s, logic lst);
        t_word w;
        w.kind = k;
        w.key_hi = h;
        w.key_lo = l;
        w.status = s;
        w.last = lst;
        due_words.push_back(w);
    endfunction

    // Drops the least recent entry; the highest age wins, the last index on ties.
    function void drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < 16; i++)
            if (slot_used[i] && (victim < 0 || slot_age[i] >= slot_age[victim]))
                victim = i;
        if (victim < 0) return;
        slot_used[victim] = 0;
        used_count--;
        push_word(lrt_pkg::KIND_EVICT, slot_hi[victim], slot_lo[victim],
                  lrt_pkg::ST_HIT, 1'b0);
    endfunction

    // Notes an accepted request word and queues the words it causes.
    function void note_request(bit release_all, logic [63:0] h, logic [63:0] l, bit ok);
        int hit;
        int free_slot;
        int cap;
        if (release_all) begin
            while (used_count > 0) drop_oldest();
            push_word(lrt_pkg::KIND_RELEASE, '0, '0, lrt_pkg::ST_HIT, 1'b1);
            return;
        end
        hit = -1;
        for (int i = 0; i < 16; i++)
            if (hit < 0 && slot_used[i] && slot_hi[i] == h && slot_lo[i] == l) hit = i;
        if (hit >= 0) begin
            for (int i = 0; i < 16; i++)
                if (slot_used[i] && slot_age[i] < slot_age[hit]) slot_age[i]++;
            slot_age[hit] = 0;
            push_word(lrt_pkg::KIND_ACCESS, h, l, lrt_pkg::ST_HIT, 1'b1);
            return;
        end
        if (!ok) begin
            push_word(lrt_pkg::KIND_ACCESS, h, l, lrt_pkg::ST_FAILED, 1'b1);
            return;
        end
        if (used_count >= 16) drop_oldest();
        free_slot = -1;
        for (int i = 0; i < 16; i++)
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
        for (int i = 0; i < 16; i++)
            if (slot_used[i]) slot_age[i]++;
        slot_hi[free_slot] = h;
        slot_lo[free_slot] = l;
        slot_used[free_slot] = 1;
        slot_age[free_slot] = 0;
        used_count++;
        cap = (cap_reg == 0) ? 1 : (cap_reg > 16 ? 16 : cap_reg);
        while (used_count > cap) drop_oldest();
        push_word(lrt_pkg::KIND_ACCESS, h, l, lrt_pkg::ST_OPENED, 1'b1);
    endfunction

    // Checks one accepted result word against the oldest expectation.
    function void check_word(t_word got);
        t_word exp_w;
        if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: kind %0d hi %h lo %h status %0d last %0d",
                         got.kind, got.key_hi, got.key_lo, got.status, got.last);
            return;
        end
        exp_w = due_words.pop_front();
        if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected kind %0d hi %h lo %h status %0d last %0d,",
                          " got kind %0d hi %h lo %h status %0d last %0d"},
                         exp_w.kind, exp_w.key_hi, exp_w.key_lo, exp_w.status,
                         exp_w.last, got.kind, got.key_hi, got.key_lo, got.status,
                         got.last);
        end
    endfunction
endclass

module tb_lru_residency_tracker_core;
    import lrt_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // tdata from bit 0: key_hi, key_lo, open_ok, zero fill.
    logic [LRT_IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: req_type.
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // tdata from bit 0: out_key_hi, out_key_lo, status, zero fill.
    logic [LRT_OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: kind.
    logic [1:0]                m_axis_tuser;
    logic                      m_axis_tlast;
    logic                      i_cfg_wr_en;
    logic [LRT_CAP_W-1:0]      i_cfg_wr_data;

    lru_scoreboard tracker_model;
    bit            stall_enable;   // when clear, neither side idles
    logic [63:0]   key_pool_hi [8];
    logic [63:0]   key_pool_lo [8];

    lru_residency_tracker_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: the receiver stalls at random and every accepted word is
    // handed to the scoreboard.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                tracker_model.check_word({t_kind'(m_axis_tuser), m_axis_tdata[63:0],
                                          m_axis_tdata[127:64],
                                          t_status'(m_axis_tdata[129:128]),
                                          m_axis_tlast});
            m_axis_tready <= !(stall_enable && $urandom_range(99) < 20);
        end
    end

    // Sends one request word, holding it until the block takes it. The block
    // cannot take another word in the cycle after, so valid drops after each word.
    task automatic send_request(bit release_all, logic [63:0] h, logic [63:0] l, bit ok);
        while (stall_enable && $urandom_range(99) < 20) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= release_all;
        s_axis_tdata  <= {7'b0, ok, l, h};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker_model.note_request(release_all, h, l, ok);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every due word has come, then a margin for leftover work.
    task automatic drain();
        while (tracker_model.due_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Capacity writes happen only while the block is idle.
    task automatic write_capacity(logic [LRT_CAP_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker_model.set_capacity(value);
    endtask

    // Random access mostly from a small key pool so hits and evictions are common.
    task automatic random_access();
        int pick;
        pick = $urandom_range(7);
        if ($urandom_range(9) == 0)
            send_request(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                         $urandom_range(1));
        else
            send_request(1'b0, key_pool_hi[pick], key_pool_lo[pick],
                         $urandom_range(99) < 75);
    endtask

    initial begin
        int caps [6];
        tracker_model = new();
        stall_enable  = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        for (int i = 0; i < 8; i++) begin
            key_pool_hi[i] = {$urandom, $urandom};
            key_pool_lo[i] = {$urandom, $urandom};
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: release on an empty tracker, extreme keys, hits,
        // failed opens, reset capacity of one, and full-tracker insertions.
        send_request(1'b1, '0, '0, 1'b0);
        send_request(1'b0, '0, '0, 1'b1);
        send_request(1'b0, '1, '1, 1'b1);
        send_request(1'b0, '1, '1, 1'b0);
        send_request(1'b0, '0, '1, 1'b0);
        write_capacity(5'd0);
        send_request(1'b0, '1, '0, 1'b1);
        write_capacity(5'd31);
        for (int i = 0; i < 17; i++)
            send_request(1'b0, 64'(i), ~64'(i), 1'b1);
        send_request(1'b0, 64'(3), ~64'(3), 1'b0);
        write_capacity(5'd3);
        send_request(1'b0, '1, '1, 1'b1);
        send_request(1'b1, '0, '0, 1'b0);

        // Random part through several capacities, one phase without idling.
        caps = '{16, 2, 5, 1, 8, 4};
        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(5'(caps[ph]));
            stall_enable = (ph != 2);
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(29) == 0) send_request(1'b1, {$urandom, $urandom},
                                                          {$urandom, $urandom},
                                                          $urandom_range(1));
                else random_access();
            end
            // Sender holds off until the block has answered everything.
            if (ph == 3) drain();
        end
        stall_enable = 1'b1;
        write_capacity(5'd16);
        for (int n = 0; n < 30; n++) random_access();
        send_request(1'b1, '0, '0, 1'b1);
        drain();

        if (tracker_model.mismatches == 0 && tracker_model.due_words.size() == 0)
            $display("tb_lru_residency_tracker_core: done, clean");
        else
            $display("tb_lru_residency_tracker_core: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_lru_residency_tracker_core: done, errors");
        $finish;
    end
endmodule
